// ----- hdl/pfa_pkg.sv -----
// Package for the partition fit allocator: request and result item types,
// status, operation and fit policy codes. No dependencies.
`default_nettype none

package pfa_pkg;

    typedef struct packed {
        logic [1:0]  op;
        logic [7:0]  job_id;
        logic [15:0] start_req;
        logic [15:0] length;
    } t_req;

    typedef struct packed {
        logic [1:0]  status;
        logic [15:0] start_res;
        logic [15:0] length_res;
    } t_res;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_NOFIT = 2'd1;
    localparam logic [1:0] ST_NOJOB = 2'd2;
    localparam logic [1:0] ST_FULL  = 2'd3;

    localparam logic [1:0] OP_ALLOC   = 2'd0;
    localparam logic [1:0] OP_RELEASE = 2'd1;
    localparam logic [1:0] OP_ADD     = 2'd2;

    localparam logic [1:0] POL_FIRST = 2'd0;
    localparam logic [1:0] POL_BEST  = 2'd1;
    localparam logic [1:0] POL_WORST = 2'd2;

endpackage

`default_nettype wire

// ----- hdl/partition_fit_allocator_top.sv -----
// Variable-partition allocator: one hole memory and one job memory with a
// sequencer that scans, edits and shifts them. Depends on pfa_pkg.
// One item at a time: a new request is taken only in the idle state, and each
// item is bounded by the sweeps over the hole and job memories.
// Reset clears the counts and the policy; memory contents need no clearing.
`default_nettype none

module partition_fit_allocator_top #(
    parameter int HOLE_SLOTS = 16,
    parameter int JOB_SLOTS  = 16,
    parameter int ADDR_BITS  = 16
) (
    input  wire             i_clk,
    input  wire             i_rst_n,
    input  wire             i_cfg_valid,
    output logic            o_cfg_ready,
    input  wire [1:0]       i_cfg_data,
    input  wire             i_req_valid,
    output logic            o_req_ready,
    input  wire pfa_pkg::t_req i_req,
    output logic            o_res_valid,
    input  wire             i_res_ready,
    output pfa_pkg::t_res   o_res
);

    localparam int AW = ADDR_BITS;
    localparam int HI = $clog2(HOLE_SLOTS);
    localparam int HC = $clog2(HOLE_SLOTS + 1);
    localparam int JI = $clog2(JOB_SLOTS);
    localparam int JC = $clog2(JOB_SLOTS + 1);
    localparam int JW = 8 + 2 * AW;

    localparam logic [4:0] S_IDLE   = 5'd0;
    localparam logic [4:0] S_AS_RD  = 5'd1;
    localparam logic [4:0] S_AS_EV  = 5'd2;
    localparam logic [4:0] S_AS_DEC = 5'd3;
    localparam logic [4:0] S_HD_RD  = 5'd4;
    localparam logic [4:0] S_HD_WR  = 5'd5;
    localparam logic [4:0] S_HU_RD  = 5'd6;
    localparam logic [4:0] S_HU_WR  = 5'd7;
    localparam logic [4:0] S_HU_INS = 5'd8;
    localparam logic [4:0] S_RJ_RD  = 5'd9;
    localparam logic [4:0] S_RJ_EV  = 5'd10;
    localparam logic [4:0] S_RH_RD  = 5'd11;
    localparam logic [4:0] S_RH_EV  = 5'd12;
    localparam logic [4:0] S_RH_DEC = 5'd13;
    localparam logic [4:0] S_JD_RD  = 5'd14;
    localparam logic [4:0] S_JD_WR  = 5'd15;
    localparam logic [4:0] S_AD_RD  = 5'd16;
    localparam logic [4:0] S_AD_EV  = 5'd17;
    localparam logic [4:0] S_AD_WR  = 5'd18;
    localparam logic [4:0] S_FIN    = 5'd19;

    function automatic logic [AW-1:0] sat_add(input logic [AW-1:0] a, input logic [AW-1:0] b);
        logic [AW:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[AW] ? {AW{1'b1}} : s[AW-1:0];
    endfunction

    // Memories: hole entry is {base, size}, job entry is {name, base, size}.
    logic [2*AW-1:0] hmem [HOLE_SLOTS];
    logic [JW-1:0]   jmem [JOB_SLOTS];
    logic [2*AW-1:0] r_hrd;
    logic [JW-1:0]   r_jrd;

    logic            h_we;
    logic [HI-1:0]   h_ra, h_wa;
    logic [2*AW-1:0] h_wd;
    logic            j_we;
    logic [JI-1:0]   j_ra, j_wa;
    logic [JW-1:0]   j_wd;

    always_ff @(posedge i_clk) begin
        if (h_we) begin
            hmem[h_wa] <= h_wd;
        end
        r_hrd <= hmem[h_ra];
    end

    always_ff @(posedge i_clk) begin
        if (j_we) begin
            jmem[j_wa] <= j_wd;
        end
        r_jrd <= jmem[j_ra];
    end

    logic [4:0]    r_state;
    logic [1:0]    r_pol;
    logic [1:0]    r_op;
    logic [7:0]    r_id;
    logic [AW-1:0] r_base, r_len;
    logic [HC-1:0] r_hcnt, r_i, r_k, r_pick;
    logic [JC-1:0] r_jcnt, r_j;
    logic          r_found, r_cvalid;
    logic [AW-1:0] r_pbase, r_psize, r_cbase, r_csize, r_jb, r_js;
    logic [1:0]    r_st;
    logic [AW-1:0] r_rb, r_rl;

    logic [AW-1:0] hb_rd, hs_rd, jb_rd, js_rd;
    logic [7:0]    jn_rd;
    logic [31:0]   in_base32, in_len32, rb32, rl32;
    logic [AW-1:0] in_base, in_len;
    logic [AW:0]   add_end, last_end, prev_end, job_end;
    logic          fits, take, first_stop, left, right;
    logic [HC-1:0] i_prev;

    assign hb_rd = r_hrd[2*AW-1:AW];
    assign hs_rd = r_hrd[AW-1:0];
    assign jn_rd = r_jrd[JW-1:2*AW];
    assign jb_rd = r_jrd[2*AW-1:AW];
    assign js_rd = r_jrd[AW-1:0];

    assign in_base32 = {16'b0, i_req.start_req};
    assign in_len32  = {16'b0, i_req.length};
    assign in_base   = in_base32[AW-1:0];
    assign in_len    = in_len32[AW-1:0];
    assign add_end   = {1'b0, in_base} + {1'b0, in_len};
    assign last_end  = {1'b0, hb_rd} + {1'b0, hs_rd};
    assign prev_end  = {1'b0, r_pbase} + {1'b0, r_psize};
    assign job_end   = {1'b0, r_jb} + {1'b0, r_js};

    assign fits = hs_rd >= r_len;
    assign take = fits && (!r_found
                  || (r_pol == pfa_pkg::POL_BEST && hs_rd < r_psize)
                  || (r_pol == pfa_pkg::POL_WORST && hs_rd > r_psize));
    assign first_stop = fits && !r_found && r_pol != pfa_pkg::POL_BEST
                        && r_pol != pfa_pkg::POL_WORST;
    assign i_prev = r_i - HC'(1);
    assign left   = (r_i != '0) && (prev_end == {1'b0, r_jb});
    assign right  = r_cvalid && (job_end == {1'b0, r_cbase});

    // Memory port control follows the sequencer state.
    always_comb begin
        h_ra = '0;
        h_we = 1'b0;
        h_wa = '0;
        h_wd = '0;
        j_ra = '0;
        j_we = 1'b0;
        j_wa = r_jcnt[JI-1:0];
        j_wd = {r_id, r_pbase, r_len};
        unique case (r_state)
            S_AS_RD: h_ra = r_i[HI-1:0];
            S_AS_DEC: begin
                j_we = r_found;
                h_we = r_found && (r_psize != r_len);
                h_wa = r_pick[HI-1:0];
                h_wd = {r_pbase + r_len, r_psize - r_len};
            end
            S_HD_RD: h_ra = HI'(r_k + HC'(1));
            S_HD_WR: begin
                h_we = 1'b1;
                h_wa = r_k[HI-1:0];
                h_wd = r_hrd;
            end
            S_HU_RD: h_ra = HI'(r_k - HC'(1));
            S_HU_WR: begin
                h_we = 1'b1;
                h_wa = r_k[HI-1:0];
                h_wd = r_hrd;
            end
            S_HU_INS: begin
                h_we = 1'b1;
                h_wa = r_i[HI-1:0];
                h_wd = {r_jb, r_js};
            end
            S_RJ_RD: j_ra = r_j[JI-1:0];
            S_RH_RD: h_ra = r_i[HI-1:0];
            S_RH_DEC: begin
                h_we = left || right;
                if (left) begin
                    h_wa = i_prev[HI-1:0];
                    h_wd = {r_pbase, right ? sat_add(sat_add(r_psize, r_js), r_csize)
                                           : sat_add(r_psize, r_js)};
                end else begin
                    h_wa = r_i[HI-1:0];
                    h_wd = {r_jb, sat_add(r_csize, r_js)};
                end
            end
            S_JD_RD: j_ra = JI'(r_j + JC'(1));
            S_JD_WR: begin
                j_we = 1'b1;
                j_wa = r_j[JI-1:0];
                j_wd = r_jrd;
            end
            S_AD_RD: h_ra = HI'(r_hcnt - HC'(1));
            S_AD_EV: begin
                h_we = ({1'b0, r_base} == last_end);
                h_wa = HI'(r_hcnt - HC'(1));
                h_wd = {hb_rd, sat_add(hs_rd, r_len)};
            end
            S_AD_WR: begin
                h_we = 1'b1;
                h_wa = r_hcnt[HI-1:0];
                h_wd = {r_base, r_len};
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_pol       <= pfa_pkg::POL_FIRST;
            r_hcnt      <= '0;
            r_jcnt      <= '0;
            o_res_valid <= 1'b0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                r_pol <= i_cfg_data;
            end
            // In the finish state a taken result is replaced by the next one below.
            if (o_res_valid && i_res_ready && r_state != S_FIN) begin
                o_res_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_req_valid) begin
                        r_op    <= i_req.op;
                        r_id    <= i_req.job_id;
                        r_base  <= in_base;
                        r_len   <= in_len;
                        r_i     <= '0;
                        r_j     <= '0;
                        r_found <= 1'b0;
                        r_st    <= pfa_pkg::ST_NOFIT;
                        r_rb    <= '0;
                        r_rl    <= '0;
                        r_state <= S_FIN;
                        case (i_req.op)
                            pfa_pkg::OP_ALLOC: begin
                                if (in_len == '0) begin
                                    r_st <= pfa_pkg::ST_NOFIT;
                                end else if (r_jcnt >= JC'(JOB_SLOTS)) begin
                                    r_st <= pfa_pkg::ST_FULL;
                                end else if (r_hcnt != '0) begin
                                    r_state <= S_AS_RD;
                                end
                            end
                            pfa_pkg::OP_RELEASE: begin
                                if (r_jcnt == '0) begin
                                    r_st <= pfa_pkg::ST_NOJOB;
                                end else begin
                                    r_state <= S_RJ_RD;
                                end
                            end
                            pfa_pkg::OP_ADD: begin
                                if (in_len != '0 && add_end <= (AW+1)'(1) << AW) begin
                                    r_state <= (r_hcnt == '0) ? S_AD_WR : S_AD_RD;
                                end
                            end
                            default: ;
                        endcase
                    end
                end
                S_AS_RD: r_state <= S_AS_EV;
                S_AS_EV: begin
                    if (take) begin
                        r_found <= 1'b1;
                        r_pick  <= r_i;
                        r_pbase <= hb_rd;
                        r_psize <= hs_rd;
                    end
                    if (first_stop || r_i + HC'(1) == r_hcnt) begin
                        r_state <= S_AS_DEC;
                    end else begin
                        r_i     <= r_i + HC'(1);
                        r_state <= S_AS_RD;
                    end
                end
                S_AS_DEC: begin
                    r_state <= S_FIN;
                    if (r_found) begin
                        r_jcnt <= r_jcnt + JC'(1);
                        r_st   <= pfa_pkg::ST_OK;
                        r_rb   <= r_pbase;
                        r_rl   <= r_len;
                        if (r_psize == r_len) begin
                            r_k     <= r_pick;
                            r_state <= S_HD_RD;
                        end
                    end
                end
                S_HD_RD: begin
                    if (r_k + HC'(1) >= r_hcnt) begin
                        r_hcnt  <= r_hcnt - HC'(1);
                        r_state <= (r_op == pfa_pkg::OP_ALLOC) ? S_FIN : S_JD_RD;
                    end else begin
                        r_state <= S_HD_WR;
                    end
                end
                S_HD_WR: begin
                    r_k     <= r_k + HC'(1);
                    r_state <= S_HD_RD;
                end
                S_HU_RD: r_state <= (r_k <= r_i) ? S_HU_INS : S_HU_WR;
                S_HU_WR: begin
                    r_k     <= r_k - HC'(1);
                    r_state <= S_HU_RD;
                end
                S_HU_INS: begin
                    r_hcnt  <= r_hcnt + HC'(1);
                    r_state <= S_JD_RD;
                end
                S_RJ_RD: r_state <= S_RJ_EV;
                S_RJ_EV: begin
                    if (jn_rd == r_id) begin
                        r_jb     <= jb_rd;
                        r_js     <= js_rd;
                        r_cvalid <= 1'b0;
                        r_state  <= (r_hcnt == '0) ? S_RH_DEC : S_RH_RD;
                    end else if (r_j + JC'(1) == r_jcnt) begin
                        r_st    <= pfa_pkg::ST_NOJOB;
                        r_state <= S_FIN;
                    end else begin
                        r_j     <= r_j + JC'(1);
                        r_state <= S_RJ_RD;
                    end
                end
                S_RH_RD: r_state <= S_RH_EV;
                S_RH_EV: begin
                    if (hb_rd > r_jb) begin
                        r_cbase  <= hb_rd;
                        r_csize  <= hs_rd;
                        r_cvalid <= 1'b1;
                        r_state  <= S_RH_DEC;
                    end else begin
                        r_pbase <= hb_rd;
                        r_psize <= hs_rd;
                        r_i     <= r_i + HC'(1);
                        r_state <= (r_i + HC'(1) == r_hcnt) ? S_RH_DEC : S_RH_RD;
                    end
                end
                S_RH_DEC: begin
                    if (left && right) begin
                        r_k     <= r_i;
                        r_state <= S_HD_RD;
                    end else if (left || right) begin
                        r_state <= S_JD_RD;
                    end else if (r_hcnt >= HC'(HOLE_SLOTS)) begin
                        r_st    <= pfa_pkg::ST_FULL;
                        r_state <= S_FIN;
                    end else begin
                        r_k     <= r_hcnt;
                        r_state <= S_HU_RD;
                    end
                end
                S_JD_RD: begin
                    if (r_j + JC'(1) >= r_jcnt) begin
                        r_jcnt  <= r_jcnt - JC'(1);
                        r_st    <= pfa_pkg::ST_OK;
                        r_rb    <= r_jb;
                        r_rl    <= r_js;
                        r_state <= S_FIN;
                    end else begin
                        r_state <= S_JD_WR;
                    end
                end
                S_JD_WR: begin
                    r_j     <= r_j + JC'(1);
                    r_state <= S_JD_RD;
                end
                S_AD_RD: r_state <= S_AD_EV;
                S_AD_EV: begin
                    r_state <= S_FIN;
                    if ({1'b0, r_base} == last_end) begin
                        r_st <= pfa_pkg::ST_OK;
                        r_rb <= r_base;
                        r_rl <= r_len;
                    end else if ({1'b0, r_base} < last_end) begin
                        r_st <= pfa_pkg::ST_NOFIT;
                    end else if (r_hcnt >= HC'(HOLE_SLOTS)) begin
                        r_st <= pfa_pkg::ST_FULL;
                    end else begin
                        r_state <= S_AD_WR;
                    end
                end
                S_AD_WR: begin
                    r_hcnt  <= r_hcnt + HC'(1);
                    r_st    <= pfa_pkg::ST_OK;
                    r_rb    <= r_base;
                    r_rl    <= r_len;
                    r_state <= S_FIN;
                end
                S_FIN: begin
                    // The finished item waits here until the output register is free.
                    if (!o_res_valid || i_res_ready) begin
                        o_res.status     <= r_st;
                        o_res.start_res  <= rb32[15:0];
                        o_res.length_res <= rl32[15:0];
                        o_res_valid      <= 1'b1;
                        r_state          <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign rb32        = 32'(r_rb);
    assign rl32        = 32'(r_rl);
    assign o_req_ready = (r_state == S_IDLE);
    assign o_cfg_ready = 1'b1;

    a_counts_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_hcnt <= HC'(HOLE_SLOTS) && r_jcnt <= JC'(JOB_SLOTS))
        else $error("hole or job count beyond table depth");

    a_error_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_res_valid) && o_res.status != pfa_pkg::ST_OK
        |-> o_res.start_res == 16'd0 && o_res.length_res == 16'd0)
        else $error("failed item carries a nonzero address or length");

    a_hcnt_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$stable(r_hcnt) |-> $past(r_state) == S_HD_RD || $past(r_state) == S_HU_INS
                             || $past(r_state) == S_AD_WR)
        else $error("hole count changed outside a table edit");

endmodule

`default_nettype wire

// ----- verif/tb_partition_fit_allocator_top.sv -----
// Testbench for partition_fit_allocator_top: a table of directed requests, then
// random allocate/release/add traffic checked against an internal allocator model.
// Depends on pfa_pkg and the RTL top level only.
`timescale 1ns / 100ps

module tb_partition_fit_allocator_top;

    localparam int SLOTS = 16;
    localparam int LIMIT = 2000000;
    localparam int DRAIN = 200;

    // Operation and policy codes outside the defined set.
    localparam logic [1:0] OP_UNKNOWN = 2'd3;
    localparam logic [1:0] POL_OTHER  = 2'd3;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_valid = 1'b0;
    logic [1:0] i_cfg_data = 2'd0;
    logic i_req_valid = 1'b0;
    logic i_res_ready = 1'b0;
    pfa_pkg::t_req i_req = '0;
    logic o_cfg_ready, o_req_ready, o_res_valid;
    pfa_pkg::t_res o_res;

    partition_fit_allocator_top dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready), .i_cfg_data(i_cfg_data),
        .i_req_valid(i_req_valid), .o_req_ready(o_req_ready), .i_req(i_req),
        .o_res_valid(o_res_valid), .i_res_ready(i_res_ready), .o_res(o_res)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Allocator model state.
    logic [15:0] m_hbase [SLOTS];
    logic [15:0] m_hsize [SLOTS];
    int          m_hcnt;
    logic [7:0]  m_jname [SLOTS];
    logic [15:0] m_jbase [SLOTS];
    logic [15:0] m_jsize [SLOTS];
    int          m_jcnt;
    logic [1:0]  m_policy;

    pfa_pkg::t_res pending_results[$];
    int errors = 0;
    int cycles = 0;
    int checked = 0;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;

    function automatic logic [15:0] sat16(int unsigned a, int unsigned b);
        int unsigned s;
        s = a + b;
        return (s > 32'hFFFF) ? 16'hFFFF : s[15:0];
    endfunction

    function automatic void drop_hole(int i);
        for (int k = i; k + 1 < m_hcnt; k++) begin
            m_hbase[k] = m_hbase[k + 1];
            m_hsize[k] = m_hsize[k + 1];
        end
        m_hcnt--;
    endfunction

    function automatic pfa_pkg::t_res allocator_outcome(pfa_pkg::t_req rq);
        pfa_pkg::t_res r;
        int pick, j, i;
        logic [15:0] jb, js;
        bit lft, rgt;
        r = '0;
        r.status = pfa_pkg::ST_NOFIT;
        case (rq.op)
            pfa_pkg::OP_ALLOC: begin
                pick = -1;
                if (rq.length == 0) return r;
                if (m_jcnt >= SLOTS) begin
                    r.status = pfa_pkg::ST_FULL;
                    return r;
                end
                for (i = 0; i < m_hcnt; i++) begin
                    if (m_hsize[i] < rq.length) continue;
                    if (pick < 0) begin
                        pick = i;
                        if (m_policy != pfa_pkg::POL_BEST && m_policy != pfa_pkg::POL_WORST)
                            break;
                    end else if (m_policy == pfa_pkg::POL_BEST
                                 && m_hsize[i] < m_hsize[pick]) begin
                        pick = i;
                    end else if (m_policy == pfa_pkg::POL_WORST
                                 && m_hsize[i] > m_hsize[pick]) begin
                        pick = i;
                    end
                end
                if (pick < 0) return r;
                r = '{pfa_pkg::ST_OK, m_hbase[pick], rq.length};
                if (m_hsize[pick] == rq.length) begin
                    drop_hole(pick);
                end else begin
                    m_hbase[pick] = m_hbase[pick] + rq.length;
                    m_hsize[pick] = m_hsize[pick] - rq.length;
                end
                m_jname[m_jcnt] = rq.job_id;
                m_jbase[m_jcnt] = r.start_res;
                m_jsize[m_jcnt] = rq.length;
                m_jcnt++;
            end
            pfa_pkg::OP_RELEASE: begin
                for (j = 0; j < m_jcnt; j++)
                    if (m_jname[j] == rq.job_id) break;
                if (j >= m_jcnt) begin
                    r.status = pfa_pkg::ST_NOJOB;
                    return r;
                end
                jb = m_jbase[j];
                js = m_jsize[j];
                for (i = 0; i < m_hcnt; i++)
                    if (m_hbase[i] > jb) break;
                lft = i > 0 && (32'(m_hbase[i - 1]) + m_hsize[i - 1] == 32'(jb));
                rgt = i < m_hcnt && (32'(jb) + js == 32'(m_hbase[i]));
                if (lft && rgt) begin
                    m_hsize[i - 1] = sat16(sat16(m_hsize[i - 1], js), m_hsize[i]);
                    drop_hole(i);
                end else if (lft) begin
                    m_hsize[i - 1] = sat16(m_hsize[i - 1], js);
                end else if (rgt) begin
                    m_hbase[i] = jb;
                    m_hsize[i] = sat16(m_hsize[i], js);
                end else begin
                    if (m_hcnt >= SLOTS) begin
                        r.status = pfa_pkg::ST_FULL;
                        return r;
                    end
                    for (int k = m_hcnt; k > i; k--) begin
                        m_hbase[k] = m_hbase[k - 1];
                        m_hsize[k] = m_hsize[k - 1];
                    end
                    m_hbase[i] = jb;
                    m_hsize[i] = js;
                    m_hcnt++;
                end
                for (int k = j; k + 1 < m_jcnt; k++) begin
                    m_jname[k] = m_jname[k + 1];
                    m_jbase[k] = m_jbase[k + 1];
                    m_jsize[k] = m_jsize[k + 1];
                end
                m_jcnt--;
                r = '{pfa_pkg::ST_OK, jb, js};
            end
            pfa_pkg::OP_ADD: begin
                int unsigned last_end;
                if (rq.length == 0 || 32'(rq.start_req) + rq.length > 32'h10000) return r;
                if (m_hcnt > 0) begin
                    last_end = 32'(m_hbase[m_hcnt - 1]) + m_hsize[m_hcnt - 1];
                    if (32'(rq.start_req) < last_end) return r;
                    if (32'(rq.start_req) == last_end) begin
                        m_hsize[m_hcnt - 1] = sat16(m_hsize[m_hcnt - 1], rq.length);
                        return '{pfa_pkg::ST_OK, rq.start_req, rq.length};
                    end
                end
                if (m_hcnt >= SLOTS) begin
                    r.status = pfa_pkg::ST_FULL;
                    return r;
                end
                m_hbase[m_hcnt] = rq.start_req;
                m_hsize[m_hcnt] = rq.length;
                m_hcnt++;
                r = '{pfa_pkg::ST_OK, rq.start_req, rq.length};
            end
            default: ;
        endcase
        return r;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        $display("mismatch %0d: %s got %0h expected %0h", checked, what, got, want);
        errors++;
    endtask

    // Result side: random stall, compare each accepted item with the oldest one.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("FAILED: results differ");
            $finish;
        end
        if (i_rst_n && o_res_valid && i_res_ready) begin
            checked++;
            if (pending_results.size() == 0) begin
                report_mismatch("unexpected item status", int'(o_res.status), 0);
            end else begin
                pfa_pkg::t_res e;
                e = pending_results.pop_front();
                if (o_res.status !== e.status)
                    report_mismatch("status", int'(o_res.status), int'(e.status));
                if (o_res.start_res !== e.start_res)
                    report_mismatch("start", int'(o_res.start_res), int'(e.start_res));
                if (o_res.length_res !== e.length_res)
                    report_mismatch("length", int'(o_res.length_res), int'(e.length_res));
            end
        end
        i_res_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    task automatic send_request(pfa_pkg::t_req rq);
        while ($urandom_range(99) < send_idle_pct) begin
            i_req_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_req_valid <= 1'b1;
        i_req <= rq;
        @(posedge i_clk);
        while (!o_req_ready) @(posedge i_clk);
        pending_results.push_back(allocator_outcome(rq));
    endtask

    task automatic wait_drained();
        i_req_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN) @(posedge i_clk);
    endtask

    task automatic write_policy(logic [1:0] pol);
        wait_drained();
        i_cfg_valid <= 1'b1;
        i_cfg_data <= pol;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        m_policy = pol;
        @(posedge i_clk);
    endtask

    function automatic pfa_pkg::t_req rand_request(int regime);
        pfa_pkg::t_req rq;
        int pick;
        rq.job_id = 8'($urandom_range(7));
        if ($urandom_range(9) == 0) rq.job_id = 8'($urandom);
        rq.start_req = 16'($urandom);
        pick = $urandom_range(99);
        if (pick < 45) begin
            rq.op = pfa_pkg::OP_ALLOC;
            rq.length = (regime == 0) ? 16'($urandom_range(1, 600)) : 16'($urandom);
            if ($urandom_range(20) == 0) rq.length = 16'd0;
        end else if (pick < 85) begin
            rq.op = pfa_pkg::OP_RELEASE;
            if (m_jcnt > 0 && $urandom_range(5) != 0)
                rq.job_id = m_jname[$urandom_range(m_jcnt - 1)];
            rq.length = 16'($urandom);
        end else if (pick < 97) begin
            rq.op = pfa_pkg::OP_ADD;
            rq.length = 16'($urandom_range(1, 4000));
            if (m_hcnt > 0 && $urandom_range(3) != 0)
                rq.start_req = 16'(m_hbase[m_hcnt - 1] + m_hsize[m_hcnt - 1]
                                   + $urandom_range(0, 64));
            if ($urandom_range(9) == 0) rq.length = 16'($urandom);
        end else begin
            rq.op = OP_UNKNOWN;
            rq.length = 16'($urandom);
        end
        return rq;
    endfunction

    typedef struct {
        pfa_pkg::t_req rq;
        bit            known;
        pfa_pkg::t_res want;
    } t_row;

    t_row script[$];

    initial begin
        t_row row;
        pfa_pkg::t_res got_model;
        for (int k = 0; k < SLOTS; k++) begin
            m_hbase[k] = 0; m_hsize[k] = 0; m_jname[k] = 0; m_jbase[k] = 0; m_jsize[k] = 0;
        end
        m_hcnt = 0;
        m_jcnt = 0;
        m_policy = pfa_pkg::POL_FIRST;

        // Directed rows; expected results typed in where obvious.
        script = '{
            '{'{pfa_pkg::OP_ALLOC,   8'h01, 16'h0000, 16'h0010}, 1,
              '{pfa_pkg::ST_NOFIT, 16'h0, 16'h0}},
            '{'{pfa_pkg::OP_RELEASE, 8'hFF, 16'hFFFF, 16'hFFFF}, 1,
              '{pfa_pkg::ST_NOJOB, 16'h0, 16'h0}},
            '{'{pfa_pkg::OP_ADD,     8'h00, 16'h0000, 16'h0000}, 1,
              '{pfa_pkg::ST_NOFIT, 16'h0, 16'h0}},
            '{'{pfa_pkg::OP_ADD,     8'h00, 16'hFFFF, 16'h0002}, 1,
              '{pfa_pkg::ST_NOFIT, 16'h0, 16'h0}},
            '{'{OP_UNKNOWN,          8'hFF, 16'hFFFF, 16'hFFFF}, 1,
              '{pfa_pkg::ST_NOFIT, 16'h0, 16'h0}},
            '{'{pfa_pkg::OP_ADD,     8'h00, 16'h0000, 16'h0100}, 1,
              '{pfa_pkg::ST_OK, 16'h0000, 16'h0100}},
            '{'{pfa_pkg::OP_ADD,     8'h00, 16'h0100, 16'h0100}, 1,
              '{pfa_pkg::ST_OK, 16'h0100, 16'h0100}},
            '{'{pfa_pkg::OP_ADD,     8'h00, 16'h0080, 16'h0010}, 1,
              '{pfa_pkg::ST_NOFIT, 16'h0, 16'h0}},
            '{'{pfa_pkg::OP_ADD,     8'h00, 16'h1000, 16'h0040}, 0, '0},
            '{'{pfa_pkg::OP_ADD,     8'h00, 16'h2000, 16'h0800}, 0, '0},
            '{'{pfa_pkg::OP_ALLOC,   8'h05, 16'h0000, 16'h0000}, 1,
              '{pfa_pkg::ST_NOFIT, 16'h0, 16'h0}},
            '{'{pfa_pkg::OP_ALLOC,   8'h05, 16'h0000, 16'hFFFF}, 1,
              '{pfa_pkg::ST_NOFIT, 16'h0, 16'h0}},
            '{'{pfa_pkg::OP_ALLOC,   8'h05, 16'hFFFF, 16'h0030}, 0, '0},
            '{'{pfa_pkg::OP_ALLOC,   8'h05, 16'h0000, 16'h0040}, 0, '0},
            '{'{pfa_pkg::OP_ALLOC,   8'h06, 16'h0000, 16'h0020}, 0, '0},
            '{'{pfa_pkg::OP_RELEASE, 8'h05, 16'h0000, 16'h0000}, 0, '0},
            '{'{pfa_pkg::OP_RELEASE, 8'h05, 16'h0000, 16'h0000}, 0, '0},
            '{'{pfa_pkg::OP_RELEASE, 8'h06, 16'h0000, 16'h0000}, 0, '0},
            '{'{pfa_pkg::OP_ADD,     8'h00, 16'hF000, 16'h1000}, 0, '0}
        };

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (script[n]) begin
            row = script[n];
            send_request(row.rq);
            got_model = pending_results[$];
            if (row.known && got_model != row.want)
                report_mismatch("directed row status", int'(got_model.status),
                                int'(row.want.status));
        end

        // Best, worst and undefined-code fit on the table left by the directed rows, then random traffic per policy.
        write_policy(pfa_pkg::POL_BEST);
        send_request('{pfa_pkg::OP_ALLOC, 8'h07, 16'h0, 16'h0010});
        write_policy(pfa_pkg::POL_WORST);
        send_request('{pfa_pkg::OP_ALLOC, 8'h08, 16'h0, 16'h0010});
        write_policy(POL_OTHER);
        send_request('{pfa_pkg::OP_ALLOC, 8'h09, 16'h0, 16'h0010});

        for (int ph = 0; ph < 16; ph++) begin
            case (ph % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 63; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 63; end
                default: begin send_idle_pct = 6; recv_stall_pct = 6; end
            endcase
            write_policy(ph % 4 == 3 ? POL_OTHER : 2'(ph % 3));
            for (int k = 0; k < 53; k++) begin
                send_request(rand_request(ph % 2));
                // Once, in phase five, the sender holds back until the block has answered everything.
                if (k == 25 && ph == 5) wait_drained();
            end
        end

        wait_drained();
        $display("run covered %0d result items over four fit policies", checked);
        $display("directed edge cases plus random allocate, release and add traffic");
        if (errors == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end
endmodule
